FILE: hdl/u8ld_pkg.sv
// ----------------------------------------------------------------------------
// u8ld_pkg: shared types and constants of the lenient UTF-8 decoder
// Field widths, count width, byte class masks and the result record.
// ----------------------------------------------------------------------------
package u8ld_pkg;

    // Field widths fixed by the stream format.
    localparam int BYTE_W  = 8;
    localparam int CP_W    = 21;
    localparam int TOTAL_W = 16;

    // Width of the internal character counter; the count saturates at all ones.
    localparam int COUNT_BITS = 16;

    // Result queue depth and its pointer and fill widths.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QFILL_W = $clog2(QDEPTH + 1);

    // Packed output data width, rounded up to whole bytes.
    localparam int MDATA_W = ((CP_W + TOTAL_W + 7) / 8) * 8;

    // Lead byte class masks and patterns.
    localparam logic [BYTE_W-1:0] ASCII_MASK = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'he0;
    localparam logic [BYTE_W-1:0] LEAD2_PAT  = 8'hc0;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hf0;
    localparam logic [BYTE_W-1:0] LEAD3_PAT  = 8'he0;
    localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hf8;
    localparam logic [BYTE_W-1:0] LEAD4_PAT  = 8'hf0;
    localparam logic [BYTE_W-1:0] LEAD2_BITS = 8'h1f;
    localparam logic [BYTE_W-1:0] CONT_BITS  = 8'h3f;
    localparam logic [BYTE_W-1:0] LEAD3_BITS = 8'h0f;
    localparam logic [BYTE_W-1:0] LEAD4_BITS = 8'h07;

    // Number of continuation bytes still expected.
    localparam logic [1:0] PEND_NONE  = 2'd0;
    localparam logic [1:0] PEND_ONE   = 2'd1;
    localparam logic [1:0] PEND_TWO   = 2'd2;
    localparam logic [1:0] PEND_THREE = 2'd3;

    // One result item.
    typedef struct packed {
        logic [CP_W-1:0]    code_point;
        logic               is_terminator;
        logic [TOTAL_W-1:0] char_total;
    } res_t;

    // Results produced by one decoded byte (up to two).
    typedef struct packed {
        logic vld0;
        logic vld1;
        res_t res0;
        res_t res1;
    } push_t;

    // Queue status seen by the decoder and the top level.
    typedef struct packed {
        logic [QFILL_W-1:0] fill;
        logic               room;
    } qstat_t;

endpackage

FILE: hdl/utf8_lenient_decoder_core.sv
// ----------------------------------------------------------------------------
// utf8_lenient_decoder_core: lenient streaming UTF-8 decoder
// Turns a byte stream into code points with a counted terminator per buffer.
// ----------------------------------------------------------------------------
// Usage:
// The slave channel takes one byte a beat in s_tdata; s_tlast marks the final
// byte of a buffer. The master channel gives one result a beat: a decoded
// code point with the running character count, and after the final byte a
// terminator beat (m_tlast high, code point zero) carrying the final count.
// A byte is registered on entry, decoded from the input register, and its
// results are registered in the result queue that drives the master channel.
// Throughput: one byte per cycle while each byte yields at most one result
// and the receiver keeps up. A final byte that also completes a character
// yields two results at once; the four-entry result queue absorbs this.
// Reset (aresetn low, synchronous) empties the input register and the queue
// and clears the decode state. When the receiver stalls, results collect in
// the queue; once fewer than two slots are free the decoder holds its byte
// and s_tready falls after the input register has filled.
// ----------------------------------------------------------------------------
module utf8_lenient_decoder_core
    import u8ld_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [BYTE_W-1:0]  s_tdata,   // [7:0] in_byte
    input  logic               s_tlast,   // buffer_end
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [MDATA_W-1:0] m_tdata,   // [20:0] code_point, [36:21] char_total, rest zero
    output logic               m_tlast    // is_terminator
);

    logic              in_vld;
    logic [BYTE_W-1:0] in_byte;
    logic              in_last;
    logic              take;
    push_t             push;
    qstat_t            qstat;
    res_t              head;

    // Input register stage.
    u8ld_in_slice u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .vld      (in_vld),
        .byte_q   (in_byte),
        .last_q   (in_last),
        .take     (take)
    );

    // A byte is decoded only when the queue can hold both possible results.
    assign take = in_vld && qstat.room;

    u8ld_decode u_dec (
        .aclk    (aclk),
        .aresetn (aresetn),
        .take    (take),
        .byte_d  (in_byte),
        .last_d  (in_last),
        .push    (push)
    );

    u8ld_res_queue u_q (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .stat     (qstat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .head     (head)
    );

    // Pack the head result onto the master channel.
    assign m_tdata = MDATA_W'({head.char_total, head.code_point});
    assign m_tlast = head.is_terminator;

    // A double push is always a character followed by the terminator.
    a_pair_order: assert property (@(posedge aclk) disable iff (!aresetn)
        push.vld1 |-> (push.vld0 && !push.res0.is_terminator && push.res1.is_terminator))
        else $error("second result of a byte is not a terminator after a character");

    // The queue never holds more than its depth.
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        qstat.fill <= QFILL_W'(QDEPTH))
        else $error("result queue overfilled");

    // Results only come from bytes actually taken from the input register.
    a_push_taken: assert property (@(posedge aclk) disable iff (!aresetn)
        push.vld0 |-> (in_vld && qstat.room))
        else $error("result pushed without a decoded byte");

    // A lone terminator is pushed only for the final byte of a buffer.
    a_term_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.vld0 && push.res0.is_terminator) |-> (in_last && !push.vld1))
        else $error("terminator pushed for a byte that does not end the buffer");

endmodule

FILE: hdl/u8ld_in_slice.sv
// ----------------------------------------------------------------------------
// u8ld_in_slice: input register stage
// Holds one accepted byte beat until the decoder consumes it.
// ----------------------------------------------------------------------------
module u8ld_in_slice
    import u8ld_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,
    input  logic              s_tlast,
    output logic              vld,
    output logic [BYTE_W-1:0] byte_q,
    output logic              last_q,
    input  logic              take
);

    logic              vld_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic              last_reg;

    // A new beat may enter when the register is empty or is being drained.
    assign s_tready = !vld_reg || take;

    // Valid flag is control state; the payload loads on every accepted beat.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (s_tready) begin
            vld_reg <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            byte_reg <= s_tdata;
            last_reg <= s_tlast;
        end
    end

    assign vld    = vld_reg;
    assign byte_q = byte_reg;
    assign last_q = last_reg;

endmodule

FILE: hdl/u8ld_decode.sv
// ----------------------------------------------------------------------------
// u8ld_decode: byte decoder and sequence state
// Classifies each byte, gathers continuation bits and forms up to two results.
// ----------------------------------------------------------------------------
module u8ld_decode
    import u8ld_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              take,
    input  logic [BYTE_W-1:0] byte_d,
    input  logic              last_d,
    output push_t             push
);

    logic [CP_W-1:0]       partial_reg, partial_next;
    logic [1:0]            pend_reg, pend_next;
    logic                  halted_reg, halted_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;

    logic                  emit;
    logic [CP_W-1:0]       emit_cp;
    logic [CP_W-1:0]       shifted;

    assign shifted = {partial_reg[CP_W-7:0], byte_d[5:0] & CONT_BITS[5:0]};

    // Sequence state update for one byte.
    always_comb begin
        partial_next = partial_reg;
        pend_next    = pend_reg;
        halted_next  = halted_reg;
        emit         = 1'b0;
        emit_cp      = '0;
        if (!halted_reg) begin
            priority if (pend_reg != PEND_NONE) begin
                partial_next = shifted;
                pend_next    = pend_reg - 2'd1;
                emit         = (pend_reg == PEND_ONE);
                emit_cp      = shifted;
            end else if (byte_d == '0) begin
                halted_next = 1'b1;
            end else if ((byte_d & ASCII_MASK) == '0) begin
                emit    = 1'b1;
                emit_cp = CP_W'(byte_d);
            end else if ((byte_d & LEAD2_MASK) == LEAD2_PAT) begin
                partial_next = CP_W'(byte_d & LEAD2_BITS);
                pend_next    = PEND_ONE;
            end else if ((byte_d & LEAD3_MASK) == LEAD3_PAT) begin
                partial_next = CP_W'(byte_d & LEAD3_BITS);
                pend_next    = PEND_TWO;
            end else if ((byte_d & LEAD4_MASK) == LEAD4_PAT) begin
                partial_next = CP_W'(byte_d & LEAD4_BITS);
                pend_next    = PEND_THREE;
            end else begin
                // Stray continuation or out-of-range lead passes through.
                emit    = 1'b1;
                emit_cp = CP_W'(byte_d);
            end
        end
        // Saturating character count.
        count_next = count_reg;
        if (emit && (count_reg != '1)) begin
            count_next = count_reg + COUNT_BITS'(1);
        end
    end

    // Results: a character first, then the terminator on the final byte.
    always_comb begin
        push.res0.code_point    = emit ? emit_cp : '0;
        push.res0.is_terminator = !emit;
        push.res0.char_total    = TOTAL_W'(count_next);
        push.res1.code_point    = '0;
        push.res1.is_terminator = 1'b1;
        push.res1.char_total    = TOTAL_W'(count_next);
        push.vld0               = take && (emit || last_d);
        push.vld1               = take && emit && last_d;
    end

    // State registers; the final byte of a buffer returns them to reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            partial_reg <= '0;
            pend_reg    <= PEND_NONE;
            halted_reg  <= 1'b0;
            count_reg   <= '0;
        end else if (take) begin
            if (last_d) begin
                partial_reg <= '0;
                pend_reg    <= PEND_NONE;
                halted_reg  <= 1'b0;
                count_reg   <= '0;
            end else begin
                partial_reg <= partial_next;
                pend_reg    <= pend_next;
                halted_reg  <= halted_next;
                count_reg   <= count_next;
            end
        end
    end

endmodule

FILE: hdl/u8ld_res_queue.sv
// ----------------------------------------------------------------------------
// u8ld_res_queue: result queue
// Small register queue taking up to two results a cycle and giving one when the receiver accepts it.
// ----------------------------------------------------------------------------
module u8ld_res_queue
    import u8ld_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  push_t  push,
    output qstat_t stat,
    output logic   m_tvalid,
    input  logic   m_tready,
    output res_t   head
);

    res_t               entry_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QFILL_W-1:0] fill_reg, fill_next;
    logic               pop;
    logic [QPTR_W-1:0]  wr_ptr_inc;

    assign pop        = m_tvalid && m_tready;
    assign wr_ptr_inc = wr_ptr_reg + QPTR_W'(1);

    // Fill change: pushes minus the pop.
    always_comb begin
        fill_next = fill_reg + QFILL_W'(push.vld0) + QFILL_W'(push.vld1) - QFILL_W'(pop);
    end

    // Pointers and fill level.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            fill_reg <= fill_next;
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push.vld1) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(2);
            end else if (push.vld0) begin
                wr_ptr_reg <= wr_ptr_inc;
            end
        end
    end

    // Entry storage; the second result goes to the following slot.
    always_ff @(posedge aclk) begin
        if (push.vld0) begin
            entry_reg[wr_ptr_reg] <= push.res0;
        end
        if (push.vld1) begin
            entry_reg[wr_ptr_inc] <= push.res1;
        end
    end

    assign m_tvalid  = (fill_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];
    assign stat.fill = fill_reg;
    assign stat.room = (fill_reg <= QFILL_W'(QDEPTH - 2));

endmodule
